>>> rtl/ffpra_pkg.sv
// shared types and constants of the fifo fill rate adapter
`default_nettype none

package ffpra_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SIGN,
        ST_MUL_P,
        ST_MUL_I,
        ST_ACC,
        ST_ROUND,
        ST_CLAMP,
        ST_MUL_R,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef logic [0:0] cfg_index_t;

    localparam cfg_index_t REG_NOMINAL  = 1'b0;
    localparam cfg_index_t REG_CAPACITY = 1'b1;

    localparam logic [17:0] NOMINAL_RESET  = 18'd48000;
    localparam logic [15:0] CAPACITY_RESET = 16'd512;

    // gains and band in q0.24
    localparam logic signed [25:0] GAIN_KP  = 26'sd50332;
    localparam logic signed [25:0] GAIN_KI  = 26'sd3355;
    localparam logic signed [25:0] Q24_ONE  = 26'sd16777216;
    localparam logic        [18:0] BAND_Q24 = 19'd335544;

    localparam int INTEGRAL_LIMIT = 50;

    localparam logic        [17:0] RATE_MAX      = 18'd262143;
    localparam logic        [43:0] RATE_HALF     = 44'd8388608;
    localparam logic signed [19:0] RATE_STEP_MIN = 20'sd4;

endpackage

`default_nettype wire

>>> rtl/ffpra_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module ffpra_div #(
    parameter int QW = 17,
    parameter int DW = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [QW+DW-1:0] dividend,
    input  wire logic [DW-1:0]    divisor,
    output logic                  done,
    output logic      [QW-1:0]    quotient
);

    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] low_reg;
    logic [DW-1:0] dvs_reg;

    logic [DW:0]   trial;
    logic          trial_ge;
    logic [DW:0]   trial_sub;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] low_next;

    // high part of the dividend is below the divisor, so the quotient fits qw bits
    always_comb
    begin
        trial     = {rem_reg, low_reg[QW-1]};
        trial_ge  = trial >= {1'b0, dvs_reg};
        trial_sub = trial - {1'b0, dvs_reg};
        rem_next  = trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
        low_next  = {low_reg[QW-2:0], trial_ge};
    end

    assign done     = busy_reg && (cnt_reg == CW'(QW - 1));
    assign quotient = low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[QW+DW-1:QW];
            low_reg <= dividend[QW-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fifo_fill_pi_rate_adapter_unit.sv
// top level of the fifo fill pi rate adapter
`default_nettype none

// path: a plain item goes straight to the output step; a regulator item runs a serial divider
//   that forms the FRAC_BITS+1 quotient bits one at a time and makes three passes through one
//   shared multiplier; a fill at or above capacity skips the divide
// flow: one item at a time, a new item taken while the last result still waits in the output
//   register; a sink stall holds the finished item in the done state and the next input waits
// reset: rst_n clears sequencer, counter and integral; nominal and claimed rate 48000, cap 512

module fifo_fill_pi_rate_adapter_unit #(
    parameter int TICK_DIVIDE = 10,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] fifo_fill
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [23:0]           m_tdata,   // [17:0] claimed_rate, [23:18] zero
    output logic      [1:0]            m_tuser,   // [0] rate_changed, [1] ticked
    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire ffpra_pkg::cfg_index_t cfg_index,
    input  wire logic [17:0]           cfg_data
);

    import ffpra_pkg::*;

    // widths that follow the fraction size
    localparam int EW  = FRAC_BITS + 2;     // error, q1.f plus sign
    localparam int IW  = FRAC_BITS + 7;     // integral, q6.f plus sign
    localparam int PW  = IW + 26;           // shared multiplier product
    localparam int AW  = FRAC_BITS + 21;    // p+i accumulator
    localparam int QW  = FRAC_BITS + 1;     // divider quotient
    localparam int DW  = 17;                // divider divisor, twice the capacity
    localparam int NW  = QW + DW;
    localparam int MW  = AW - FRAC_BITS;    // rounded adjustment magnitude

    localparam logic        [3:0]    TICK_LAST = 4'(TICK_DIVIDE);
    localparam logic signed [EW-1:0] ERR_ONE   = EW'(2 ** FRAC_BITS);
    localparam logic signed [IW:0]   ISUM_LIM  = (IW + 1)'(INTEGRAL_LIMIT * (2 ** FRAC_BITS));
    localparam logic        [AW-1:0] ROUND_HALF = AW'(2 ** (FRAC_BITS - 1));

    // sequencer
    state_t state_reg;
    state_t state_next;

    // configuration and long-lived state
    logic        [17:0]   nominal_reg;
    logic        [15:0]   cap_reg;
    logic        [3:0]    tick_count_reg;
    logic signed [IW-1:0] integ_reg;
    logic        [17:0]   cur_rate_reg;

    // per-item working registers
    logic        [15:0]   fill_reg;
    logic                 neg_reg;
    logic signed [EW-1:0] err_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic        [MW-1:0] adjmag_reg;
    logic                 adj_neg_reg;
    logic signed [19:0]   adj_reg;
    logic                 changed_reg;
    logic                 ticked_reg;

    // output register
    logic                 m_tvalid_reg;
    logic        [17:0]   out_rate_reg;
    logic                 out_changed_reg;
    logic                 out_ticked_reg;

    // handshake and control decode
    logic in_take;
    logic cfg_take;
    logic idle;
    logic div_start;
    logic out_load;

    // tick counter
    logic [3:0] tick_inc;
    logic       tick_hit;

    // error preparation
    logic          fill_sat;
    logic [16:0]   twice_fill;
    logic          err_neg;
    logic [16:0]   err_mag17;
    logic [NW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic          div_done;
    logic [QW-1:0] div_q;

    // integral update
    logic signed [IW:0]   integ_sum;
    logic signed [IW-1:0] integ_new;

    // shared multiplier
    logic signed [IW-1:0] mul_a;
    logic signed [25:0]   mul_b;

    // adjustment rounding and clamp
    logic [AW-1:0] acc_abs;
    logic [AW-1:0] acc_rnd;
    logic [18:0]   adj_lim;

    // rate update
    logic        [43:0] rate_sum;
    logic        [19:0] rate_raw;
    logic        [17:0] rate_new;
    logic signed [19:0] rate_diff;
    logic               rate_move;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid;
    assign in_take   = s_tvalid && idle;
    assign s_tready  = idle;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_rate_reg};
    assign m_tuser  = {out_ticked_reg, out_changed_reg};

    // tick every TICK_DIVIDE-th item
    assign tick_inc = tick_count_reg + 4'd1;
    assign tick_hit = tick_inc >= TICK_LAST;

    // fill at or above capacity saturates the error at +1.0
    always_comb
    begin
        fill_sat     = fill_reg >= cap_reg;
        twice_fill   = {fill_reg, 1'b0};
        err_neg      = twice_fill < {1'b0, cap_reg};
        err_mag17    = err_neg ? ({1'b0, cap_reg} - twice_fill)
                               : (twice_fill - {1'b0, cap_reg});
        // round half away: (2*mag*2^f + cap) / (2*cap)
        div_dividend = NW'({err_mag17[15:0], {(FRAC_BITS + 1){1'b0}}}) + NW'(cap_reg);
        div_divisor  = {cap_reg, 1'b0};
    end

    ffpra_div #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // integral with anti-windup clamp
    always_comb
    begin
        integ_sum = (IW + 1)'(integ_reg) + (IW + 1)'(err_reg);
        if (integ_sum > ISUM_LIM)
        begin
            integ_new = IW'(ISUM_LIM);
        end
        else if (integ_sum < -ISUM_LIM)
        begin
            integ_new = IW'(-ISUM_LIM);
        end
        else
        begin
            integ_new = integ_sum[IW-1:0];
        end
    end

    // operand select for the one multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_P:
            begin
                mul_a = IW'(err_reg);
                mul_b = GAIN_KP;
            end
            ST_MUL_I:
            begin
                mul_a = integ_reg;
                mul_b = GAIN_KI;
            end
            ST_MUL_R:
            begin
                mul_a = IW'($signed({1'b0, nominal_reg}));
                mul_b = Q24_ONE + 26'(adj_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // adjustment: shift by f rounding half away, then clamp to the band
    always_comb
    begin
        acc_abs = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        acc_rnd = acc_abs + ROUND_HALF;
        adj_lim = (adjmag_reg > MW'(BAND_Q24)) ? BAND_Q24 : adjmag_reg[18:0];
    end

    // new rate rounded from q24, saturated, with a dead band that ignores steps below 4 hz
    always_comb
    begin
        rate_sum  = prod_reg[43:0] + RATE_HALF;
        rate_raw  = rate_sum[43:24];
        rate_new  = (rate_raw > 20'(RATE_MAX)) ? RATE_MAX : rate_raw[17:0];
        rate_diff = $signed({2'b00, rate_new}) - $signed({2'b00, cur_rate_reg});
        rate_move = (rate_diff >= RATE_STEP_MIN) || (rate_diff <= -RATE_STEP_MIN);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (tick_hit && (cap_reg != 16'd0)) ? ST_PREP : ST_DONE;
                end
            end
            ST_PREP:   state_next = fill_sat ? ST_MUL_P : ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:   state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_I;
            ST_MUL_I:  state_next = ST_ACC;
            ST_ACC:    state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_MUL_R;
            ST_MUL_R:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control decode
    always_comb
    begin
        idle      = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: idle      = 1'b1;
            ST_PREP: div_start = !fill_sat;
            ST_DONE: out_load  = !m_tvalid_reg || m_tready;
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            nominal_reg     <= NOMINAL_RESET;
            cap_reg         <= CAPACITY_RESET;
            tick_count_reg  <= 4'd0;
            integ_reg       <= '0;
            cur_rate_reg    <= NOMINAL_RESET;
            changed_reg     <= 1'b0;
            ticked_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            out_changed_reg <= 1'b0;
            out_ticked_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // the user must issue register writes only while idle; the block itself does not enforce it
            if (cfg_take)
            begin
                unique case (cfg_index)
                    REG_NOMINAL:
                    begin
                        nominal_reg  <= cfg_data;
                        cur_rate_reg <= cfg_data;
                    end
                    REG_CAPACITY: cap_reg <= cfg_data[15:0];
                    default:      cap_reg <= cap_reg;
                endcase
            end

            if (in_take)
            begin
                tick_count_reg <= tick_hit ? 4'd0 : tick_inc;
                ticked_reg     <= tick_hit && (cap_reg != 16'd0);
                changed_reg    <= 1'b0;
            end

            if (state_reg == ST_MUL_P)
            begin
                integ_reg <= integ_new;
            end

            if ((state_reg == ST_UPDATE) && rate_move)
            begin
                cur_rate_reg <= rate_new;
                changed_reg  <= 1'b1;
            end

            // output register, loaded when empty or while the sink takes the old item
            if (out_load)
            begin
                m_tvalid_reg    <= 1'b1;
                out_changed_reg <= changed_reg;
                out_ticked_reg  <= ticked_reg;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            fill_reg <= s_tdata;
        end

        if (state_reg == ST_PREP)
        begin
            neg_reg <= err_neg;
            if (fill_sat)
            begin
                err_reg <= ERR_ONE;
            end
        end

        if (state_reg == ST_SIGN)
        begin
            err_reg <= neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        end

        if ((state_reg == ST_MUL_P) || (state_reg == ST_MUL_I) || (state_reg == ST_MUL_R))
        begin
            prod_reg <= mul_a * mul_b;
        end

        if (state_reg == ST_MUL_I)
        begin
            acc_reg <= prod_reg[AW-1:0];
        end
        else if (state_reg == ST_ACC)
        begin
            acc_reg <= acc_reg + prod_reg[AW-1:0];
        end

        if (state_reg == ST_ROUND)
        begin
            adjmag_reg  <= acc_rnd[AW-1:FRAC_BITS];
            adj_neg_reg <= acc_reg[AW-1];
        end

        if (state_reg == ST_CLAMP)
        begin
            adj_reg <= adj_neg_reg ? -$signed({1'b0, adj_lim}) : $signed({1'b0, adj_lim});
        end

        if (out_load)
        begin
            out_rate_reg <= cur_rate_reg;
        end
    end

`ifndef ASSERT_OFF
    // a rate change is reported only on a regulator item
    a_changed_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_changed_reg) |-> out_ticked_reg)
        else $error("rate change reported without a regulator run");

    // anti-windup keeps the integral inside its limit
    a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= IW'(ISUM_LIM)) && (integ_reg >= IW'(-ISUM_LIM)))
        else $error("integral outside its limit");

    // the divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside the divide step");

    // the claimed rate moves only on a nominal write or a rate update
    a_rate_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cur_rate_reg) |->
            ($past(state_reg) == ST_UPDATE) ||
            $past(cfg_valid && (cfg_index == REG_NOMINAL)))
        else $error("claimed rate changed without cause");

    // an accepted item either runs the regulator or goes straight to the output
    a_take_path: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP) || (state_reg == ST_DONE))
        else $error("accepted item took no valid path");
`endif

endmodule

`default_nettype wire

>>> bench/fill_rate_checker.sv
`timescale 1ns / 100ps
// checker of the fifo fill rate adapter: predicts each claimed rate and compares results
module fill_rate_checker #(
    parameter int TICK_DIVIDE = 10,
    parameter int FRAC_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  ffpra_pkg::cfg_index_t cfg_index,
    input  logic [17:0]           cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam longint KP_Q24      = 50332;
    localparam longint KI_Q24      = 3355;
    localparam longint ADJ_BAND    = 335544;
    localparam longint INTEG_LIMIT = 50;
    localparam longint RATE_CEIL   = 262143;
    localparam longint MIN_STEP    = 4;

    typedef struct packed {
        logic [17:0] rate;
        logic        changed;
        logic        ticked;
    } rate_item_t;

    rate_item_t  expected_rates[$];
    logic [17:0] nominal;
    logic [15:0] capacity;
    logic [3:0]  tick_cnt;
    longint      integral;
    logic [17:0] rate_now;
    int          miss_cnt;
    int          result_idx;

    function automatic longint div_away(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint shift_away(longint v, int sh);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q   = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // advances the regulator state by one fill event and returns the claimed rate
    function automatic rate_item_t regulate_fill(logic [15:0] fill);
        rate_item_t res;
        longint     one;
        longint     cap;
        longint     err;
        longint     adj;
        longint     target;
        longint     step;
        one         = longint'(1) << FRAC_BITS;
        res.changed = 1'b0;
        res.ticked  = 1'b0;
        tick_cnt    = tick_cnt + 4'd1;
        if (tick_cnt >= TICK_DIVIDE) begin
            tick_cnt = 4'd0;
            if (capacity != 16'd0) begin
                res.ticked = 1'b1;
                cap        = longint'(capacity);
                err        = div_away((2 * longint'(fill) - cap) * one, cap);
                err        = clamp_sym(err, one);
                integral   = clamp_sym(integral + err, INTEG_LIMIT * one);
                adj        = shift_away(KP_Q24 * err + KI_Q24 * integral, FRAC_BITS);
                adj        = clamp_sym(adj, ADJ_BAND);
                target     = (longint'(nominal) * ((longint'(1) << 24) + adj)
                              + (longint'(1) << 23)) >>> 24;
                if (target > RATE_CEIL) target = RATE_CEIL;
                step = target - longint'(rate_now);
                if (step >= MIN_STEP || step <= -MIN_STEP) begin
                    rate_now    = target[17:0];
                    res.changed = 1'b1;
                end
            end
        end
        res.rate = rate_now;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        rate_item_t want;
        rate_item_t got;
        if (!rst_n) begin
            expected_rates.delete();
            nominal     = ffpra_pkg::NOMINAL_RESET;
            capacity    = ffpra_pkg::CAPACITY_RESET;
            tick_cnt    = 4'd0;
            integral    = 0;
            rate_now    = ffpra_pkg::NOMINAL_RESET;
            miss_cnt    = 0;
            result_idx  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ffpra_pkg::REG_NOMINAL) begin
                    nominal  = cfg_data;
                    rate_now = cfg_data;
                end
                else if (cfg_index == ffpra_pkg::REG_CAPACITY) begin
                    capacity = cfg_data[15:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got.rate    = m_tdata[17:0];
                got.changed = m_tuser[0];
                got.ticked  = m_tuser[1];
                if (expected_rates.size() == 0) begin
                    miss_cnt++;
                    if (miss_cnt <= 10)
                        $display(
                            "result %0d unexpected: rate %0d changed %0b ticked %0b",
                            result_idx, got.rate, got.changed, got.ticked);
                end
                else begin
                    want = expected_rates.pop_front();
                    if (got.rate !== want.rate || got.changed !== want.changed
                        || got.ticked !== want.ticked) begin
                        miss_cnt++;
                        if (miss_cnt <= 10)
                            $display(
                                "result %0d: exp %0d/%0b/%0b got %0d/%0b/%0b (rate/chg/tick)",
                                result_idx, want.rate, want.changed, want.ticked,
                                got.rate, got.changed, got.ticked);
                    end
                end
                result_idx++;
            end
            if (s_tvalid && s_tready)
                expected_rates.push_back(regulate_fill(s_tdata));
            mismatches  <= miss_cnt;
            outstanding <= expected_rates.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// testbench top of the fifo fill pi rate adapter: stimulus, handshakes and verdict
module tb;

    import ffpra_pkg::*;

    // run ends with a failure past this many cycles
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 2000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;   // [15:0] fifo_fill
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;             // [17:0] claimed_rate, [23:18] zero
    logic [1:0]  m_tuser;             // [0] rate_changed, [1] ticked
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = REG_NOMINAL;
    logic [17:0] cfg_data  = 18'd0;

    int          err_count;
    int          open_count;
    int          cycles    = 0;
    // no random idling on either side while set
    bit          quiet     = 1'b0;
    // capacity currently programmed, used to aim the fill levels
    int          cur_cap   = 512;

    always #5 clk = ~clk;

    fifo_fill_pi_rate_adapter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fill_rate_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (err_count),
        .outstanding (open_count)
    );

    // receiver stalls at random about 7 percent of the time, unless quiet is set
    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(0, 99) >= 7);

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one fill item, with an occasional idle gap before it; valid stays high afterwards
    task automatic send_fill(input logic [15:0] fill);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= fill;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending and wait until every claimed rate has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
    endtask

    // register write; valid is dropped again before the task returns
    task automatic write_reg(input cfg_index_t idx, input logic [17:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_CAPACITY)
            cur_cap = value[15:0];
    endtask

    initial begin : stimulus
        logic [15:0] first_fills[9];
        int          sent;
        int          phase;
        int          run_len;
        int          aim;
        int          spread;
        int          jitter;
        int          level;
        int          mode;
        logic [17:0] nom_pick;
        logic [15:0] cap_pick;

        first_fills = '{16'd0, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd1,
                        16'h8000, 16'd256, 16'd511, 16'd512};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // reset config, tick on a fill far above capacity: error saturates at full
        foreach (first_fills[i])
            send_fill(first_fills[i]);
        send_fill(16'hFFFF);

        // largest nominal rate and capacity: rate computation saturates at its ceiling
        drain_results();
        write_reg(REG_NOMINAL, 18'h3FFFF);
        write_reg(REG_CAPACITY, 16'hFFFF);
        for (int i = 0; i < 9; i++)
            send_fill(16'(i * 7000));
        send_fill(16'hFFFF);

        // capacity zero: the tick skips the regulator entirely
        drain_results();
        write_reg(REG_CAPACITY, 16'd0);
        write_reg(REG_NOMINAL, 18'd1000);
        for (int i = 0; i < 10; i++)
            send_fill(16'(i * 4321));

        // --- random phases, each with its own settings and fill pattern ---
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            // registers only change once everything is back
            drain_results();
            case ($urandom_range(0, 9))
                0:       nom_pick = 18'd1000;
                1:       nom_pick = 18'd192000;
                2:       nom_pick = 18'h3FFFF;
                3:       nom_pick = 18'd0;
                default: nom_pick = 18'($urandom_range(1000, 192000));
            endcase
            case ($urandom_range(0, 9))
                0:       cap_pick = 16'd0;
                1:       cap_pick = 16'd512;
                2:       cap_pick = 16'hFFFF;
                3:       cap_pick = 16'd1;
                default: cap_pick = 16'($urandom_range(512, 65535));
            endcase
            // nominal write reloads the rate, so skip it now and then to keep history
            if (phase == 0 || $urandom_range(0, 9) < 7)
                write_reg(REG_NOMINAL, nom_pick);
            write_reg(REG_CAPACITY, cap_pick);

            quiet   = (phase == 2);
            run_len = $urandom_range(100, 400);
            // persistent offsets wind the integral up to its clamp
            mode    = $urandom_range(0, 4);
            case (mode)
                0:       aim = cur_cap / 2;
                1:       aim = cur_cap + 200;
                2:       aim = 0;
                3:       aim = cur_cap / 2 + cur_cap / 8;
                default: aim = $urandom_range(0, cur_cap);
            endcase
            spread = cur_cap / 32 + 4;

            for (int i = 0; i < run_len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise over the whole field
                    level = $urandom_range(0, 65535);
                end
                else begin
                    jitter = $urandom_range(0, 2 * spread);
                    level  = aim + jitter - spread;
                    if (level < 0) level = 0;
                    if (level > 65535) level = 65535;
                end
                send_fill(16'(level));
            end
            sent += run_len;
            phase++;
        end
        quiet = 1'b0;

        // --- wind down ---
        drain_results();
        repeat (40) @(posedge clk);
        if (err_count == 0 && open_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
